// ===== sv/bia_pkg.sv =====
`default_nettype none
package bia_pkg;

  localparam int MAX_IDS = 1024;
  localparam int ID_W    = 10;
  localparam int CNT_W   = 11;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD     = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NONE_FREE = 3'd1;
  localparam logic [STAT_W-1:0] ST_TAKEN     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd4;

  localparam logic [CNT_W-1:0] ID_COUNT_RESET = CNT_W'(MAX_IDS);

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  req_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/bitmap_id_allocator.sv =====
`default_nettype none
// A result beat is set valid at the end of the exec state, which follows the accept
// in the idle state. No new request is taken until the read-modify-write of one
// bitmap word in the map memory ends (read in the accept cycle, write in the next).
// Reset (synchronous, active high) sets the count to 1024 and the free count to
// 1024; the map is cleared at once through per-word valid flags, no clearing pass.
module bitmap_id_allocator #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire bia_pkg::req_t             req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output bia_pkg::rsp_t                  rsp,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bia_pkg::CNT_W-1:0] cfg_data
);
  import bia_pkg::*;

  // WORD_BITS is a power of two, so an identifier splits into a word address
  // (upper bits) and a bit position (lower bits).
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = ID_W - BIT_W;
  localparam int MAP_WORDS = 1 << ADDR_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // The map memory holds one used bit per identifier. A word whose valid flag
  // is clear has not been written since the last reset or count write and
  // reads as all free.
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [MAP_WORDS-1:0] word_valid;
  // A word is full when every identifier in it below the count is used.
  // Words that lie entirely at or above the count are always full.
  logic [MAP_WORDS-1:0] word_full;

  logic             state;
  logic [CNT_W-1:0] id_count;
  logic [CNT_W-1:0] free_ids;

  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   req_id_q;
  logic [ADDR_W-1:0] addr_q;
  logic              word_found_q;

  logic              accept;
  logic              exec_go;
  logic              cfg_write;

  logic              word_found;
  logic [ADDR_W-1:0] word_index;
  logic [ADDR_W-1:0] rd_addr;

  logic [WORD_BITS-1:0] word_cur;
  logic [WORD_BITS-1:0] oor_mask;
  logic [WORD_BITS-1:0] word_new;
  logic                 bit_found;
  logic [BIT_W-1:0]     bit_index;
  logic [BIT_W-1:0]     req_bit;
  logic                 req_oor;
  logic                 wr_en;
  logic [CNT_W-1:0]     free_ids_next;
  rsp_t                 rsp_next;
  logic [CNT_W-1:0]     count_clamped;

  // The handshake. Requests are held off while a word is being modified or
  // while a finished result beat still waits downstream.
  assign req_stall = (state == ST_EXEC) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign exec_go   = (state == ST_EXEC) && !(rsp_valid && rsp_stall);
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;

  assign count_clamped = (cfg_data > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : cfg_data;

  // Lowest word that still has a free identifier below the count.
  bia_ffs #(
    .WIDTH (MAP_WORDS)
  ) u_word_ffs (
    .bits  (~word_full),
    .found (word_found),
    .index (word_index)
  );

  assign rd_addr = (req.cmd == CMD_ALLOC) ? word_index : req.req_id[ID_W-1:BIT_W];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= map_mem[rd_addr];
    end
    if (wr_en) begin
      map_mem[addr_q] <= word_new;
    end
  end

  // Modify stage. The word read in the accept cycle is combined with the
  // out-of-range mask so that the search never returns an identifier at or
  // above the count.
  assign word_cur = word_valid[addr_q] ? rd_data : '0;
  assign req_bit  = req_id_q[BIT_W-1:0];
  assign req_oor  = ({1'b0, req_id_q} >= id_count);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      oor_mask[b] = ({1'b0, addr_q, BIT_W'(b)} >= id_count);
    end
  end

  bia_ffs #(
    .WIDTH (WORD_BITS)
  ) u_bit_ffs (
    .bits  (~(word_cur | oor_mask)),
    .found (bit_found),
    .index (bit_index)
  );

  always_comb begin
    word_new            = word_cur;
    wr_en               = 1'b0;
    free_ids_next       = free_ids;
    rsp_next.result_id  = '0;
    rsp_next.status     = ST_OK;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (word_found_q && bit_found) begin
          word_new[bit_index] = 1'b1;
          wr_en               = exec_go;
          free_ids_next       = free_ids - 1'b1;
          rsp_next.result_id  = {addr_q, bit_index};
        end else begin
          rsp_next.status = ST_NONE_FREE;
        end
      end
      CMD_CLAIM: begin
        if (req_oor) begin
          rsp_next.status = ST_RANGE;
        end else if (word_cur[req_bit]) begin
          rsp_next.status = ST_TAKEN;
        end else begin
          word_new[req_bit]  = 1'b1;
          wr_en              = exec_go;
          free_ids_next      = (free_ids != '0) ? free_ids - 1'b1 : free_ids;
          rsp_next.result_id = req_id_q;
        end
      end
      CMD_RELEASE: begin
        if (req_oor) begin
          rsp_next.status = ST_RANGE;
        end else if (!word_cur[req_bit]) begin
          rsp_next.status = ST_NOT_ALLOC;
        end else begin
          word_new[req_bit]  = 1'b0;
          wr_en              = exec_go;
          free_ids_next      = (free_ids < id_count) ? free_ids + 1'b1 : free_ids;
          rsp_next.result_id = req_id_q;
        end
      end
      CMD_BAD: begin
        rsp_next.status = ST_RANGE;
      end
      default: begin
        rsp_next.status = ST_RANGE;
      end
    endcase
    rsp_next.free_count = free_ids_next;
  end

  // Request registers hold the command for the modify cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q        <= req.cmd;
      req_id_q     <= req.req_id;
      addr_q       <= rd_addr;
      word_found_q <= word_found;
    end
  end

  // Control state, count registers and per-word flags. A count write clears
  // every valid flag and marks as full exactly the words beyond the new count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      id_count   <= ID_COUNT_RESET;
      free_ids   <= ID_COUNT_RESET;
      word_valid <= '0;
      for (int w = 0; w < MAP_WORDS; w++) begin
        word_full[w] <= ({1'b0, ADDR_W'(w), {BIT_W{1'b0}}} >= ID_COUNT_RESET);
      end
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_write) begin
        id_count   <= count_clamped;
        free_ids   <= count_clamped;
        word_valid <= '0;
        for (int w = 0; w < MAP_WORDS; w++) begin
          word_full[w] <= ({1'b0, ADDR_W'(w), {BIT_W{1'b0}}} >= count_clamped);
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state     <= ST_IDLE;
            rsp_valid <= 1'b1;
            free_ids  <= free_ids_next;
            if (wr_en) begin
              word_valid[addr_q] <= 1'b1;
              word_full[addr_q]  <= &(word_new | oor_mask);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The result register is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bia_ffs.sv =====
`default_nettype none
// Finds the lowest set bit of a vector.
module bia_ffs #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0]         bits,
  output logic                          found,
  output logic [$clog2(WIDTH)-1:0]      index
);

  always_comb begin
    found = |bits;
    index = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (bits[i]) begin
        index = ($clog2(WIDTH))'(i);
      end
    end
  end

endmodule
`default_nettype wire
